// ===== hdl/rfd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rfd_pkg
// Shared types and constants of the remote frame decoder: frame length,
// register indexes, register reset values and the packed response layout.
// ---------------------------------------------------------------------------
package rfd_pkg;

   // Frame geometry
   localparam int unsigned FRAME_LEN = 18;
   localparam int unsigned CNT_W     = 5;

   // Register indexes on the csr port
   localparam logic [1:0] REG_STICK_CENTER = 2'd0;
   localparam logic [1:0] REG_STICK_LIMIT  = 2'd1;
   localparam logic [1:0] REG_MOUSE_LIMIT  = 2'd2;
   localparam logic [1:0] REG_WHEEL_FOLD   = 2'd3;

   // Register reset values
   localparam logic [10:0] STICK_CENTER_RST = 11'd1024;
   localparam logic [9:0]  STICK_LIMIT_RST  = 10'd660;
   localparam logic [14:0] MOUSE_LIMIT_RST  = 15'd1024;
   localparam logic [14:0] WHEEL_FOLD_RST   = 15'd3000;

   // Response payload, last field (right_x) in the lowest bits (152 bits total)
   typedef struct packed {
      logic [3:0]  pad;
      logic [3:0]  change_flags;
      logic [15:0] wheel;
      logic [15:0] key_bits;
      logic [15:0] mouse_buttons;
      logic [15:0] mouse_z;
      logic [15:0] mouse_y;
      logic [15:0] mouse_x;
      logic [3:0]  switches;
      logic [10:0] left_y;
      logic [10:0] left_x;
      logic [10:0] right_y;
      logic [10:0] right_x;
   } rsp_type;

   localparam int unsigned RSP_W = $bits(rsp_type);

endpackage

// ===== hdl/remote_frame_decoder.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// remote_frame_decoder
// Assembles an 18-byte remote-control frame and decodes it into one response.
// ---------------------------------------------------------------------------
// One frame byte is taken per request, one per clock at full rate. A byte
// flagged as frame start restarts assembly; bytes past the 18th are dropped
// until the next frame start. Once the last byte of a frame is taken, a
// decode is pending; it runs in one pass from the stored frame into the
// response register as soon as that register is empty or its response is
// being taken. Intake stalls only when a completed frame waits for decode
// while the response register still holds a response the consumer has not
// taken.
module remote_frame_decoder
   import rfd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] byte_value
   input  logic             req_tuser,   // [0] frame_start
   // response channel
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // right_x, right_y, left_x, left_y, switches,
                                         // mouse_x, mouse_y, mouse_z, mouse_buttons,
                                         // key_bits, wheel, change_flags, zero pad
   // configuration
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [14:0]      csr_wdata
);

   // Stick: center a nonzero raw value or keep the held one, then clip
   function automatic logic [10:0] stick_next(input logic [10:0] raw,
                                              input logic [10:0] held,
                                              input logic [10:0] center,
                                              input logic [9:0]  lim);
      logic signed [11:0] val;
      logic signed [11:0] lim_s;
      lim_s = signed'({2'b00, lim});
      if (raw != 11'd0) begin
         val = signed'({1'b0, raw}) - signed'({1'b0, center});
      end else begin
         val = signed'({held[10], held});
      end
      if (val > lim_s || val < -lim_s) begin
         return 11'd0;
      end
      return val[10:0];
   endfunction

   // Mouse axis: zero when the magnitude exceeds the limit
   function automatic logic [15:0] mouse_clip(input logic [15:0] v,
                                              input logic [14:0] lim);
      logic signed [16:0] val;
      logic signed [16:0] lim_s;
      val   = signed'({v[15], v});
      lim_s = signed'({2'b00, lim});
      if (val > lim_s || val < -lim_s) begin
         return 16'd0;
      end
      return v;
   endfunction

   // Configuration registers
   logic [10:0] stick_center_ff;
   logic [9:0]  stick_limit_ff;
   logic [14:0] mouse_limit_ff;
   logic [14:0] wheel_fold_ff;

   // Assembly state
   logic [7:0]       frame_bytes_ff [FRAME_LEN];
   logic [CNT_W-1:0] byte_count_ff, byte_count_in;
   logic             dec_pend_ff, dec_pend_in;

   // Decode history
   logic [10:0] held_ff [4];
   logic [10:0] held_in [4];
   logic [3:0]  last_sw_ff;
   logic [15:0] last_btn_ff;

   // Response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic             req_fire;
   logic             dec_fire;
   logic [CNT_W-1:0] slot;
   logic             slot_ok;
   logic [10:0]      raw [4];
   logic [1:0]       sw_l, sw_r;
   logic [15:0]      buttons;
   logic [15:0]      wheel_t;

   // Handshake: decode when the response register is free or draining
   assign dec_fire   = dec_pend_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !dec_pend_ff || dec_fire;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         stick_center_ff <= STICK_CENTER_RST;
         stick_limit_ff  <= STICK_LIMIT_RST;
         mouse_limit_ff  <= MOUSE_LIMIT_RST;
         wheel_fold_ff   <= WHEEL_FOLD_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_STICK_CENTER: stick_center_ff <= csr_wdata[10:0];
            REG_STICK_LIMIT:  stick_limit_ff  <= csr_wdata[9:0];
            REG_MOUSE_LIMIT:  mouse_limit_ff  <= csr_wdata;
            REG_WHEEL_FOLD:   wheel_fold_ff   <= csr_wdata;
         endcase
      end
   end

   // Byte slot for the incoming request
   always_comb begin
      slot          = req_tuser ? '0 : byte_count_ff;
      slot_ok       = (slot < CNT_W'(FRAME_LEN));
      byte_count_in = byte_count_ff;
      dec_pend_in   = dec_pend_ff && !dec_fire;
      if (req_fire && slot_ok) begin
         byte_count_in = slot + CNT_W'(1);
         if (slot == CNT_W'(FRAME_LEN - 1)) begin
            dec_pend_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         dec_pend_ff   <= 1'b0;
      end else begin
         byte_count_ff <= byte_count_in;
         dec_pend_ff   <= dec_pend_in;
      end
   end

   // Store the byte; the stored frame is stable while a decode is pending
   always_ff @(posedge clock) begin
      if (req_fire && slot_ok) begin
         frame_bytes_ff[slot] <= req_tdata;
      end
   end

   // Decode the stored frame
   always_comb begin
      raw[0] = {frame_bytes_ff[1][2:0], frame_bytes_ff[0]};
      raw[1] = {frame_bytes_ff[2][5:0], frame_bytes_ff[1][7:3]};
      raw[2] = {frame_bytes_ff[4][0], frame_bytes_ff[3], frame_bytes_ff[2][7:6]};
      raw[3] = {frame_bytes_ff[5][3:0], frame_bytes_ff[4][7:1]};
      for (int i = 0; i < 4; i++) begin
         held_in[i] = stick_next(raw[i], held_ff[i], stick_center_ff, stick_limit_ff);
      end

      sw_l    = frame_bytes_ff[5][7:6];
      sw_r    = frame_bytes_ff[5][5:4];
      buttons = {frame_bytes_ff[13], frame_bytes_ff[12]};

      // Center the wheel with 16-bit wrap, fold above the threshold
      wheel_t = {5'd0, stick_center_ff} - {frame_bytes_ff[17], frame_bytes_ff[16]};

      rsp_data_in.right_x       = held_in[0];
      rsp_data_in.right_y       = held_in[1];
      rsp_data_in.left_x        = held_in[2];
      rsp_data_in.left_y        = held_in[3];
      rsp_data_in.switches      = {sw_l, sw_r};
      rsp_data_in.mouse_x       = mouse_clip({frame_bytes_ff[7], frame_bytes_ff[6]},
                                             mouse_limit_ff);
      rsp_data_in.mouse_y       = mouse_clip({frame_bytes_ff[9], frame_bytes_ff[8]},
                                             mouse_limit_ff);
      rsp_data_in.mouse_z       = {frame_bytes_ff[11], frame_bytes_ff[10]};
      rsp_data_in.mouse_buttons = buttons;
      rsp_data_in.key_bits      = {frame_bytes_ff[15], frame_bytes_ff[14]};
      rsp_data_in.wheel         = (signed'(wheel_t) > signed'({1'b0, wheel_fold_ff})) ?
                                  ~wheel_t : wheel_t;
      rsp_data_in.change_flags  = {buttons[7:0]  != last_btn_ff[7:0],
                                   buttons[15:8] != last_btn_ff[15:8],
                                   sw_r != last_sw_ff[1:0],
                                   sw_l != last_sw_ff[3:2]};
      rsp_data_in.pad           = '0;

      rsp_valid_in = dec_fire || (rsp_valid_ff && !rsp_tready);
   end

   // Advance history on each decode
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            held_ff[i] <= '0;
         end
         last_sw_ff  <= '0;
         last_btn_ff <= '0;
      end else if (dec_fire) begin
         for (int i = 0; i < 4; i++) begin
            held_ff[i] <= held_in[i];
         end
         last_sw_ff  <= rsp_data_in.switches;
         last_btn_ff <= buttons;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dec_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== hdl/rfd_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rfd_checker
// Port-level checks on the remote frame decoder response channel.
// ---------------------------------------------------------------------------
module rfd_checker
   import rfd_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   rsp_type rsp;
   assign rsp = rsp_type'(rsp_tdata);

   // Hold a stalled response unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed or dropped");

   // Drop any response across reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // Clipped sticks never reach the most negative code
   a_stick_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp.right_x != 11'h400 && rsp.right_y != 11'h400 &&
                     rsp.left_x != 11'h400 && rsp.left_y != 11'h400)
      else $error("stick value outside clip range");

   // Clipped mouse axes never reach the most negative code
   a_mouse_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp.mouse_x != 16'h8000 && rsp.mouse_y != 16'h8000)
      else $error("mouse value outside clip range");

endmodule

bind remote_frame_decoder rfd_checker u_rfd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== verif/remote_frame_decoder_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// remote_frame_decoder_checker
// Watches the request, response and csr ports of the remote frame decoder.
// It keeps its own frame buffer, held sticks and register copies, predicts
// one response per completed frame and compares each response, with its
// pad bits masked, against the oldest prediction.
// ---------------------------------------------------------------------------
module remote_frame_decoder_checker
   import rfd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic             req_tuser,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [14:0]      csr_wdata,
   output int               pending_count,
   output int               mismatch_count
);

   // register copies
   logic [10:0] center;
   logic [9:0]  stick_lim;
   logic [14:0] mouse_lim;
   logic [14:0] fold_lim;

   // frame assembly and held decode state
   logic [7:0]  frame_buf [FRAME_LEN];
   int unsigned fill;
   int          held [4];
   logic [3:0]  prev_switches;
   logic [15:0] prev_buttons;

   rsp_type     decoded_q [$];
   int          errors = 0;

   initial begin
      pending_count  = 0;
      mismatch_count = 0;
   end

   // Zero a value whose magnitude exceeds the limit
   function automatic int clip_to_zero(int v, int lim);
      return (v > lim || v < -lim) ? 0 : v;
   endfunction

   function automatic int sext16(logic [15:0] v);
      int r;
      r = {{16{v[15]}}, v};
      return r;
   endfunction

   function automatic string show(rsp_type r);
      return $sformatf({"rx=%0d ry=%0d lx=%0d ly=%0d sw=%h mx=%0d my=%0d mz=%0d",
                        " btn=%h keys=%h wheel=%0d flags=%h"},
                       $signed(r.right_x), $signed(r.right_y), $signed(r.left_x),
                       $signed(r.left_y), r.switches, $signed(r.mouse_x),
                       $signed(r.mouse_y), $signed(r.mouse_z), r.mouse_buttons,
                       r.key_bits, $signed(r.wheel), r.change_flags);
   endfunction

   // Decode the assembled frame; updates held sticks and change history
   function automatic rsp_type decode_frame();
      logic [47:0] stick_bits;
      logic [10:0] raw;
      logic [1:0]  sw_left;
      logic [1:0]  sw_right;
      logic [15:0] buttons;
      logic [15:0] wheel_diff;
      int          t;
      rsp_type     r;
      stick_bits = {frame_buf[5], frame_buf[4], frame_buf[3],
                    frame_buf[2], frame_buf[1], frame_buf[0]};
      r = '0;
      for (int i = 0; i < 4; i++) begin
         raw = stick_bits[11*i +: 11];
         // a raw zero keeps the held value, the limit applies either way
         if (raw != 11'd0)
            held[i] = int'(raw) - int'(center);
         held[i] = clip_to_zero(held[i], int'(stick_lim));
      end
      r.right_x = 11'(held[0]);
      r.right_y = 11'(held[1]);
      r.left_x  = 11'(held[2]);
      r.left_y  = 11'(held[3]);

      sw_left    = frame_buf[5][7:6];
      sw_right   = frame_buf[5][5:4];
      r.switches = {sw_left, sw_right};

      r.mouse_x = 16'(clip_to_zero(sext16({frame_buf[7], frame_buf[6]}), int'(mouse_lim)));
      r.mouse_y = 16'(clip_to_zero(sext16({frame_buf[9], frame_buf[8]}), int'(mouse_lim)));
      r.mouse_z = {frame_buf[11], frame_buf[10]};
      buttons         = {frame_buf[13], frame_buf[12]};
      r.mouse_buttons = buttons;
      r.key_bits      = {frame_buf[15], frame_buf[14]};

      // center the wheel, fold above the threshold, wrap to 16 bits
      wheel_diff = {5'd0, center} - {frame_buf[17], frame_buf[16]};
      t = sext16(wheel_diff);
      if (t > int'(fold_lim))
         r.wheel = 16'(65535 - t);
      else
         r.wheel = 16'(t);

      r.change_flags[0] = (sw_left != prev_switches[3:2]);
      r.change_flags[1] = (sw_right != prev_switches[1:0]);
      r.change_flags[2] = (buttons[15:8] != prev_buttons[15:8]);
      r.change_flags[3] = (buttons[7:0] != prev_buttons[7:0]);
      prev_switches = r.switches;
      prev_buttons  = buttons;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         center        = STICK_CENTER_RST;
         stick_lim     = STICK_LIMIT_RST;
         mouse_lim     = MOUSE_LIMIT_RST;
         fold_lim      = WHEEL_FOLD_RST;
         fill          = 0;
         held          = '{default: 0};
         prev_switches = '0;
         prev_buttons  = '0;
         decoded_q.delete();
      end else begin
         // compare the response against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got     = rsp_tdata;
            got.pad = '0;
            if (decoded_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: response with none expected: %s", $realtime, show(got));
            end else begin
               want = decoded_q.pop_front();
               if (got != want) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t: response mismatch", $realtime);
                     $display("   expected %s", show(want));
                     $display("   actual   %s", show(got));
                  end
               end
            end
         end

         // track register writes
         if (csr_we) begin
            case (csr_index)
               REG_STICK_CENTER: center    = csr_wdata[10:0];
               REG_STICK_LIMIT:  stick_lim = csr_wdata[9:0];
               REG_MOUSE_LIMIT:  mouse_lim = csr_wdata[14:0];
               REG_WHEEL_FOLD:   fold_lim  = csr_wdata[14:0];
               default: ;
            endcase
         end

         // assemble the frame, drop bytes past its end
         if (req_tvalid && req_tready) begin
            if (req_tuser)
               fill = 0;
            if (fill < FRAME_LEN) begin
               frame_buf[fill] = req_tdata;
               fill++;
               if (fill == FRAME_LEN)
                  decoded_q.push_back(decode_frame());
            end
         end
      end
      pending_count  <= decoded_q.size();
      mismatch_count <= errors;
   end

endmodule

// ===== verif/remote_frame_decoder_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// remote_frame_decoder_test
// Drives byte streams of remote-control frames into the decoder under a
// series of register settings, with random idling on both channels and one
// long response stall, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module remote_frame_decoder_test;
   import rfd_pkg::*;

   localparam int ITEM_TARGET     = 1400;
   localparam int PHASE_COUNT     = 7;
   localparam int PHASE_ITEMS     = ITEM_TARGET / PHASE_COUNT;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 4;
   localparam int TAIL_CYCLES     = 8;

   logic             clock;
   logic             reset       = 1'b1;
   logic             req_tvalid  = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata   = '0;
   logic             req_tuser   = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready  = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_we      = 1'b0;
   logic [1:0]       csr_index   = REG_STICK_CENTER;
   logic [14:0]      csr_wdata   = '0;

   int pending_count;
   int mismatch_count;

   // idling shape, shared with the response process
   int send_idle_pct = 20;
   int recv_idle_pct = 82;
   bit hold_off_req  = 1'b0;

   // current register values, used to aim stimulus at the limits
   int cur_center    = STICK_CENTER_RST;
   int cur_stick_lim = STICK_LIMIT_RST;
   int cur_mouse_lim = MOUSE_LIMIT_RST;
   int cur_fold      = WHEEL_FOLD_RST;

   int          items        = 0;
   int          dropped      = 0;
   int          responses    = 0;
   logic [3:0]  last_sw      = '0;
   logic [15:0] last_buttons = '0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   remote_frame_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   remote_frame_decoder_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .pending_count  (pending_count),
      .mismatch_count (mismatch_count)
   );

   // Response side: random ready, with one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         responses++;

   // Watchdog: end the run if nothing moves for too long
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no request or response moved for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   // Offer one request, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] value, input logic first);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= first;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   // Drop valid and wait until every predicted response has been taken
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
   endtask

   // One csr write; the caller holds csr_we high
   task automatic put_reg(input logic [1:0] index, input logic [14:0] value);
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Write all four registers; dirty fills the unused upper bits of the stick center and stick limit
   task automatic write_settings(input int c, input int s, input int m, input int f,
                                 input bit dirty);
      logic [14:0] hi;
      hi            = dirty ? 15'($urandom) : 15'd0;
      cur_center    = c & 'h7ff;
      cur_stick_lim = s & 'h3ff;
      cur_mouse_lim = m & 'h7fff;
      cur_fold      = f & 'h7fff;
      csr_we <= 1'b1;
      put_reg(REG_STICK_CENTER, {hi[14:11], 11'(c)});
      put_reg(REG_STICK_LIMIT,  {hi[14:10], 10'(s)});
      put_reg(REG_MOUSE_LIMIT,  15'(m));
      put_reg(REG_WHEEL_FOLD,   15'(f));
      csr_we <= 1'b0;
   endtask

   // Raw stick value aimed at zero, the limit edges and the extremes
   function automatic logic [10:0] pick_stick();
      case ($urandom_range(0, 6))
         0: return 11'd0;
         1: return 11'(cur_center + cur_stick_lim);
         2: return 11'(cur_center - cur_stick_lim);
         3: return 11'(cur_center + cur_stick_lim + 1);
         4: return 11'(cur_center - cur_stick_lim - 1);
         5: return 11'h7ff;
         default: return 11'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_mouse();
      case ($urandom_range(0, 6))
         0: return 16'(cur_mouse_lim);
         1: return 16'(-cur_mouse_lim);
         2: return 16'(cur_mouse_lim + 1);
         3: return 16'(-cur_mouse_lim - 1);
         4: return 16'h8000;
         5: return 16'h7fff;
         default: return 16'($urandom);
      endcase
   endfunction

   // One sequence: mostly whole frames, some with trailing junk, some
   // aborted by a restart, and loose noise bytes
   task automatic send_sequence();
      logic [143:0] frame;
      logic [10:0]  sticks [4];
      logic [15:0]  wheel_raw;
      int           kind;
      int           n;
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
         for (int i = 0; i < 4; i++)
            sticks[i] = pick_stick();
         if ($urandom_range(0, 1))
            last_sw = 4'($urandom);
         if ($urandom_range(0, 1))
            last_buttons[7:0] = 8'($urandom);
         if ($urandom_range(0, 1))
            last_buttons[15:8] = 8'($urandom);
         case ($urandom_range(0, 6))
            0: wheel_raw = 16'(cur_center - cur_fold);
            1: wheel_raw = 16'(cur_center - cur_fold - 1);
            2: wheel_raw = 16'(cur_center);
            3: wheel_raw = 16'(cur_center + 1);
            4: wheel_raw = 16'hffff;
            5: wheel_raw = 16'h0000;
            default: wheel_raw = 16'($urandom);
         endcase
         frame = {wheel_raw, 16'($urandom), last_buttons, 16'($urandom),
                  pick_mouse(), pick_mouse(), last_sw,
                  sticks[3], sticks[2], sticks[1], sticks[0]};
         for (int i = 0; i < FRAME_LEN; i++)
            send_byte(frame[8*i +: 8], i == 0);
         items += FRAME_LEN;
         // bytes past the end are dropped by the block
         if (kind >= 75) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
               send_byte(8'($urandom), 1'b0);
            dropped += n;
         end
      end else if (kind < 93) begin
         n = $urandom_range(1, FRAME_LEN - 1);
         for (int i = 0; i < n; i++)
            send_byte(8'($urandom), i == 0);
         items += n;
      end else begin
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++)
            send_byte(8'($urandom), $urandom_range(0, 3) == 0);
         items += n;
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // frame before any start flag, all ones: every stick beyond the limit
      for (int i = 0; i < FRAME_LEN; i++)
         send_byte(8'hff, 1'b0);
      items += FRAME_LEN;
      // bytes past the end of the frame
      send_byte(8'h00, 1'b0);
      send_byte(8'h5a, 1'b0);
      dropped += 2;
      // short frame cut off by the next start
      send_byte(8'h00, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      items += 3;

      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p > 0) begin
            drain();
            repeat (SETTLE_CYCLES) @(posedge clock);
            case (p)
               1: write_settings(0, 0, 0, 0, 1'b0);
               2: write_settings(2047, 1023, 32767, 32767, 1'b0);
               3: write_settings($urandom, $urandom, $urandom, $urandom, 1'b1);
               4: write_settings(STICK_CENTER_RST, STICK_LIMIT_RST, MOUSE_LIMIT_RST,
                                 WHEEL_FOLD_RST, 1'b1);
               5: write_settings($urandom_range(900, 1150), $urandom_range(300, 900),
                                 $urandom_range(0, 3000), $urandom_range(0, 6000), 1'b0);
               default: write_settings($urandom, $urandom, $urandom, $urandom, 1'b1);
            endcase
         end
         // stall the response side long enough to back up the input
         if (p == 5)
            hold_off_req = 1'b1;
         while (items < (p + 1) * PHASE_ITEMS) begin
            if (items < ITEM_TARGET / 3) begin
               send_idle_pct = 20;
               recv_idle_pct = 82;
            end else if (items < 2 * ITEM_TARGET / 3) begin
               send_idle_pct = 82;
               recv_idle_pct = 20;
            end else begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            send_sequence();
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d frame bytes plus %0d dropped trailing bytes, %0d decoded frames",
               items, dropped, responses);
      $display("over %0d register settings, with a %0d-cycle response stall",
               PHASE_COUNT, HOLD_OFF_CYCLES);
      if (mismatch_count == 0 && pending_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
